// ----- rtl/nat_pkg.sv -----
package nat_pkg;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EXP_W = 7;
  localparam logic [15:0] FIRST_PORT_RST = 16'd1024;
  localparam logic [15:0] LAST_PORT_RST = 16'd11023;
  localparam logic [15:0] ICMP_TIMEOUT_RST = 16'd60;

  typedef enum logic [1:0] {
    OP_LOOKUP_EXT = 2'd0,
    OP_LOOKUP_INT = 2'd1,
    OP_INSERT     = 2'd2,
    OP_TICK       = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_HIT  = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2,
    ST_TICK = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_FIRST_PORT   = 2'd0,
    REG_LAST_PORT    = 2'd1,
    REG_ICMP_TIMEOUT = 2'd2,
    REG_NONE         = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESP
  } state_e;

  typedef struct packed {
    logic        kind;
    logic [31:0] address;
    logic [15:0] inside_port;
    logic [15:0] outside_port;
    logic [31:0] stamp;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic start;
    logic scan;
  } cmd_t;

  typedef struct packed {
    logic direct;
    logic scan_done;
  } sts_t;

endpackage

// ----- rtl/nat_ram.sv -----
module nat_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- rtl/nat_ctrl.sv -----
module nat_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  nat_pkg::sts_t sts_i,
  output nat_pkg::cmd_t cmd_o
);

  nat_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nat_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      nat_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d = sts_i.direct ? nat_pkg::S_RESP : nat_pkg::S_SCAN;
        end
      end
      nat_pkg::S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = nat_pkg::S_RESP;
        end
      end
      nat_pkg::S_RESP: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = nat_pkg::S_IDLE;
        end
      end
      default: state_d = nat_pkg::S_IDLE;
    endcase
  end

endmodule

// ----- rtl/nat_dpath.sv -----
module nat_dpath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  nat_pkg::cmd_t              cmd_i,
  output nat_pkg::sts_t              sts_o,
  input  logic [1:0]                 in_opcode_i,
  input  logic                       in_kind_i,
  input  logic [31:0]                in_inside_address_i,
  input  logic [15:0]                in_inside_port_i,
  input  logic [15:0]                in_outside_port_i,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_index_i,
  input  logic [15:0]                cfg_data_i,
  output logic [1:0]                 out_status_o,
  output logic                       out_found_kind_o,
  output logic [31:0]                out_found_address_o,
  output logic [15:0]                out_found_inside_port_o,
  output logic [15:0]                out_found_outside_port_o,
  output logic [nat_pkg::EXP_W-1:0]  out_expired_count_o
);

  localparam int unsigned IW = nat_pkg::IDX_W;
  localparam int unsigned CW = nat_pkg::CNT_W;

  logic [15:0] first_q, last_q, tmo_q;
  logic [31:0] sec_q, sec_d;
  logic [15:0] icmp_q, icmp_d, tcp_q, tcp_d;
  logic [CW-1:0] count_q, count_d, left_q, left_d, rem_q, rem_d;
  logic [IW-1:0] ridx_q, ridx_d, lidx_q, lidx_d, widx_q, widx_d;
  logic pend_q, pend_d;
  nat_pkg::op_e op_q, op_d;
  logic kind_q, kind_d;
  logic [31:0] addr_q, addr_d;
  logic [15:0] iport_q, iport_d, oport_q, oport_d;
  nat_pkg::entry_t res_q, res_d;
  nat_pkg::status_e rst_q, rst_d;
  logic [CW-1:0] rcnt_q, rcnt_d;

  logic we;
  logic [IW-1:0] waddr;
  nat_pkg::entry_t wdata, rdata;
  logic [nat_pkg::ENTRY_W-1:0] rdata_raw;
  logic hit, expire;
  logic [31:0] age;
  logic [15:0] ext;

  nat_ram #(.WIDTH(nat_pkg::ENTRY_W), .DEPTH(nat_pkg::TABLE_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (ridx_q),
    .rdata_o (rdata_raw)
  );

  assign rdata = nat_pkg::entry_t'(rdata_raw);

  function automatic logic [15:0] step_ctr(input logic [15:0] cur, input logic [15:0] first,
                                           input logic [15:0] last);
    logic [16:0] nxt;
    nxt = {1'b0, cur} + 17'd1;
    return (nxt > {1'b0, last}) ? first : nxt[15:0];
  endfunction

  assign hit = (rdata.kind == kind_q) &&
               ((op_q == nat_pkg::OP_LOOKUP_EXT) ? (rdata.outside_port == oport_q) :
                ((rdata.address == addr_q) && (rdata.inside_port == iport_q)));
  assign age = sec_q - rdata.stamp;
  assign expire = !rdata.kind && (age > {16'd0, tmo_q});
  assign ext = in_kind_i ? tcp_q : icmp_q;

  always_comb begin
    sts_o.direct    = (in_opcode_i == nat_pkg::OP_INSERT);
    sts_o.scan_done = (pend_q && op_q != nat_pkg::OP_TICK && hit) ||
                      (!pend_q && left_q == '0);
  end

  always_comb begin
    sec_d = sec_q; icmp_d = icmp_q; tcp_d = tcp_q; count_d = count_q;
    left_d = left_q; rem_d = rem_q; ridx_d = ridx_q; lidx_d = lidx_q;
    widx_d = widx_q; pend_d = pend_q; op_d = op_q; kind_d = kind_q;
    addr_d = addr_q; iport_d = iport_q; oport_d = oport_q;
    res_d = res_q; rst_d = rst_q; rcnt_d = rcnt_q;
    we = 1'b0; waddr = widx_q; wdata = rdata;

    if (cmd_i.start) begin
      op_d = nat_pkg::op_e'(in_opcode_i);
      kind_d = in_kind_i; addr_d = in_inside_address_i;
      iport_d = in_inside_port_i; oport_d = in_outside_port_i;
      left_d = count_q; pend_d = 1'b0; rem_d = '0; widx_d = '0;
      res_d = '0; rcnt_d = '0;
      case (nat_pkg::op_e'(in_opcode_i))
        nat_pkg::OP_INSERT: begin
          if (count_q == CW'(nat_pkg::TABLE_DEPTH)) begin
            rst_d = nat_pkg::ST_FULL;
          end else begin
            rst_d = nat_pkg::ST_HIT;
            we = 1'b1;
            waddr = count_q[IW-1:0];
            wdata = '{kind: in_kind_i, address: in_inside_address_i,
                      inside_port: in_inside_port_i, outside_port: ext, stamp: sec_q};
            res_d = wdata;
            res_d.stamp = '0;
            count_d = count_q + CW'(1);
            if (in_kind_i) tcp_d = step_ctr(tcp_q, first_q, last_q);
            else icmp_d = step_ctr(icmp_q, first_q, last_q);
          end
        end
        nat_pkg::OP_TICK: begin
          sec_d = sec_q + 32'd1;
          ridx_d = '0;
        end
        default: begin
          // newest entry sits at the highest address
          ridx_d = IW'(count_q - CW'(1));
        end
      endcase
    end else if (cmd_i.scan) begin
      // one read issued per cycle, its data checked in the next cycle
      pend_d = (left_q != '0);
      if (left_q != '0) begin
        left_d = left_q - CW'(1);
        lidx_d = ridx_q;
        ridx_d = (op_q == nat_pkg::OP_TICK) ? ridx_q + IW'(1) : ridx_q - IW'(1);
      end
      if (op_q == nat_pkg::OP_TICK) begin
        if (pend_q) begin
          if (expire) begin
            rem_d = rem_q + CW'(1);
          end else begin
            we = 1'b1;
            waddr = widx_q;
            widx_d = widx_q + IW'(1);
          end
        end
        if (sts_o.scan_done) begin
          rst_d = nat_pkg::ST_TICK;
          rcnt_d = rem_q;
          count_d = count_q - rem_q;
        end
      end else if (pend_q && hit) begin
        we = 1'b1;
        waddr = lidx_q;
        wdata.stamp = sec_q;
        rst_d = nat_pkg::ST_HIT;
        res_d = rdata;
        res_d.stamp = '0;
      end else if (sts_o.scan_done) begin
        rst_d = nat_pkg::ST_MISS;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= nat_pkg::FIRST_PORT_RST;
      last_q  <= nat_pkg::LAST_PORT_RST;
      tmo_q   <= nat_pkg::ICMP_TIMEOUT_RST;
      sec_q   <= '0;
      icmp_q  <= nat_pkg::FIRST_PORT_RST;
      tcp_q   <= nat_pkg::FIRST_PORT_RST;
      count_q <= '0;
      left_q  <= '0;
      rem_q   <= '0;
      ridx_q  <= '0;
      lidx_q  <= '0;
      widx_q  <= '0;
      pend_q  <= 1'b0;
      op_q    <= nat_pkg::OP_LOOKUP_EXT;
      kind_q  <= 1'b0;
      addr_q  <= '0;
      iport_q <= '0;
      oport_q <= '0;
      res_q   <= '0;
      rst_q   <= nat_pkg::ST_MISS;
      rcnt_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (nat_pkg::reg_e'(cfg_index_i))
          nat_pkg::REG_FIRST_PORT:   first_q <= cfg_data_i;
          nat_pkg::REG_LAST_PORT:    last_q  <= cfg_data_i;
          nat_pkg::REG_ICMP_TIMEOUT: tmo_q   <= cfg_data_i;
          default: ;
        endcase
      end
      sec_q <= sec_d; icmp_q <= icmp_d; tcp_q <= tcp_d; count_q <= count_d;
      left_q <= left_d; rem_q <= rem_d; ridx_q <= ridx_d; lidx_q <= lidx_d;
      widx_q <= widx_d; pend_q <= pend_d; op_q <= op_d; kind_q <= kind_d;
      addr_q <= addr_d; iport_q <= iport_d; oport_q <= oport_d;
      res_q <= res_d; rst_q <= rst_d; rcnt_q <= rcnt_d;
    end
  end

  assign out_status_o             = rst_q;
  assign out_found_kind_o         = res_q.kind;
  assign out_found_address_o      = res_q.address;
  assign out_found_inside_port_o  = res_q.inside_port;
  assign out_found_outside_port_o = res_q.outside_port;
  assign out_expired_count_o      = nat_pkg::EXP_W'(rcnt_q);

endmodule

// ----- rtl/nat_mapping_table.sv -----
// Insert or full: result registered at the accept edge, beat in the next cycle.
// Lookup and tick: one table entry read per cycle from the RAM; a lookup
// stops early at its first match. One item at a time; next item accepted
// the cycle after the result beat.
// Reset (async, active low) empties the table via the fill count; no clear pass.
module nat_mapping_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  in_opcode_i,
  input  logic        in_kind_i,
  input  logic [31:0] in_inside_address_i,
  input  logic [15:0] in_inside_port_i,
  input  logic [15:0] in_outside_port_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  out_status_o,
  output logic        out_found_kind_o,
  output logic [31:0] out_found_address_o,
  output logic [15:0] out_found_inside_port_o,
  output logic [15:0] out_found_outside_port_o,
  output logic [6:0]  out_expired_count_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  nat_pkg::cmd_t cmd;
  nat_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  nat_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  nat_dpath u_dpath (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .cmd_i                    (cmd),
    .sts_o                    (sts),
    .in_opcode_i              (in_opcode_i),
    .in_kind_i                (in_kind_i),
    .in_inside_address_i      (in_inside_address_i),
    .in_inside_port_i         (in_inside_port_i),
    .in_outside_port_i        (in_outside_port_i),
    .cfg_we_i                 (cfg_valid_i),
    .cfg_index_i              (cfg_index_i),
    .cfg_data_i               (cfg_data_i),
    .out_status_o             (out_status_o),
    .out_found_kind_o         (out_found_kind_o),
    .out_found_address_o      (out_found_address_o),
    .out_found_inside_port_o  (out_found_inside_port_o),
    .out_found_outside_port_o (out_found_outside_port_o),
    .out_expired_count_o      (out_expired_count_o)
  );

endmodule
